/* hdl/diagonal_hit_clumper_defines.svh */
// Assertion macros used by the diagonal hit clumper checker.
// No dependencies; the including scope must provide clk_i and rst_ni.
`ifndef DIAGONAL_HIT_CLUMPER_DEFINES_SVH
`define DIAGONAL_HIT_CLUMPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dhc_pkg.sv */
// Types and constants of the diagonal hit clumper.
// No dependencies; used by every design module of the block.
package dhc_pkg;

  localparam int unsigned PosW   = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_HITS  = 2'd0,
    CFG_MAX_GAP   = 2'd1,
    CFG_TILE_SIZE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] min_hits;
    logic [30:0] max_gap;
    logic [3:0]  tile_size;
  } cfg_t;

  typedef struct packed {
    logic            is_flush;
    logic [PosW-1:0] query_pos;
    logic [PosW-1:0] target_pos;
    logic [PosW-1:0] diag;
  } hit_t;

  typedef struct packed {
    logic [PosW-1:0]   query_first;
    logic [PosW-1:0]   query_end;
    logic [PosW-1:0]   target_first;
    logic [PosW-1:0]   target_end;
    logic [CountW-1:0] clump_hits;
  } clump_t;

endpackage

/* hdl/diagonal_hit_clumper.sv */
// Diagonal hit clumper: groups diagonal-sorted seed hits into clumps.
// Data path: input register, then the clump core decision, then the result register.
// Throughput: one hit or flush per cycle while the result register is not stalled.
// Stalls only while the result register holds an untaken clump.
// Reset (async, active low) clears the open clump, both valid flags and
// loads the register defaults min_hits 3, max_gap 2, tile_size 10.
module diagonal_hit_clumper (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dhc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dhc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         is_flush_i,
  input  logic [31:0]                  query_pos_i,
  input  logic [31:0]                  target_pos_i,
  input  logic [31:0]                  diag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [31:0]                  query_first_o,
  output logic [31:0]                  query_end_o,
  output logic [31:0]                  target_first_o,
  output logic [31:0]                  target_end_o,
  output logic [31:0]                  clump_hits_o
);

  dhc_pkg::cfg_t   cfg;
  dhc_pkg::hit_t   hit_in, hit_cur;
  dhc_pkg::clump_t clump_next, clump_out;
  logic            hit_valid;
  logic            out_free;
  logic            advance;
  logic            emit;

  assign cfg_ready_o = 1'b1;

  assign hit_in.is_flush   = is_flush_i;
  assign hit_in.query_pos  = query_pos_i;
  assign hit_in.target_pos = target_pos_i;
  assign hit_in.diag       = diag_i;

  // Advance only when the result register can take a clump.
  assign advance = hit_valid && out_free;

  dhc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dhc_in_reg u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .hit_i       (hit_in),
    .advance_i   (advance),
    .hit_valid_o (hit_valid),
    .hit_o       (hit_cur)
  );

  dhc_clump_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .hit_i    (hit_cur),
    .step_i   (advance),
    .emit_o   (emit),
    .result_o (clump_next)
  );

  dhc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && emit),
    .result_i    (clump_next),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (clump_out)
  );

  assign query_first_o  = clump_out.query_first;
  assign query_end_o    = clump_out.query_end;
  assign target_first_o = clump_out.target_first;
  assign target_end_o   = clump_out.target_end;
  assign clump_hits_o   = clump_out.clump_hits;

endmodule

/* hdl/dhc_cfg_regs.sv */
// Configuration registers of the diagonal hit clumper.
// Depends on dhc_pkg.
module dhc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [dhc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dhc_pkg::CfgDataW-1:0]  cfg_data_i,
  output dhc_pkg::cfg_t                 cfg_o
);

  dhc_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dhc_pkg::CFG_MIN_HITS:  cfg_d.min_hits  = cfg_data_i[15:0];
        dhc_pkg::CFG_MAX_GAP:   cfg_d.max_gap   = cfg_data_i[30:0];
        dhc_pkg::CFG_TILE_SIZE: cfg_d.tile_size = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_hits  <= 16'd3;
      cfg_q.max_gap   <= 31'd2;
      cfg_q.tile_size <= 4'd10;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/dhc_in_reg.sv */
// Input register holding one hit or flush transaction.
// Depends on dhc_pkg.
module dhc_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dhc_pkg::hit_t hit_i,
  input  logic          advance_i,
  output logic          hit_valid_o,
  output dhc_pkg::hit_t hit_o
);

  logic          valid_d, valid_q;
  dhc_pkg::hit_t hit_q;
  logic          load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hit_q <= hit_i;
    end
  end

  assign hit_valid_o = valid_q;
  assign hit_o       = hit_q;

endmodule

/* hdl/dhc_clump_core.sv */
// Open-clump state and the close/extend decision for one transaction.
// Depends on dhc_pkg.
module dhc_clump_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dhc_pkg::cfg_t   cfg_i,
  input  dhc_pkg::hit_t   hit_i,
  input  logic            step_i,
  output logic            emit_o,
  output dhc_pkg::clump_t result_o
);

  logic [dhc_pkg::CountW-1:0] count_d, count_q;
  logic [dhc_pkg::PosW-1:0]   q_low_d, q_low_q, q_high_d, q_high_q;
  logic [dhc_pkg::PosW-1:0]   t_low_d, t_low_q, t_high_d, t_high_q;
  logic [dhc_pkg::PosW-1:0]   prev_diag_d, prev_diag_q;
  logic                       have_prev_d, have_prev_q;

  logic [dhc_pkg::PosW-1:0]   diag_step;
  logic [dhc_pkg::CountW-1:0] need;
  logic                       gap_break;
  logic                       qualifies;
  logic [dhc_pkg::PosW-1:0]   tile_ext;

  // Step wraps modulo 2^32, so a descending diagonal usually breaks the clump.
  assign diag_step = hit_i.diag - prev_diag_q;
  assign gap_break = have_prev_q && (diag_step > {1'b0, cfg_i.max_gap});
  assign need      = (cfg_i.min_hits == 16'd0) ? 32'd1 : {16'd0, cfg_i.min_hits};
  assign qualifies = have_prev_q && (count_q != '0) && (count_q >= need);
  assign emit_o    = (hit_i.is_flush || gap_break) && qualifies;

  assign tile_ext = {28'd0, cfg_i.tile_size};
  assign result_o.query_first  = q_low_q;
  assign result_o.query_end    = q_high_q + tile_ext;
  assign result_o.target_first = t_low_q;
  assign result_o.target_end   = t_high_q + tile_ext;
  assign result_o.clump_hits   = count_q;

  always_comb begin
    count_d     = count_q;
    q_low_d     = q_low_q;
    q_high_d    = q_high_q;
    t_low_d     = t_low_q;
    t_high_d    = t_high_q;
    prev_diag_d = prev_diag_q;
    have_prev_d = have_prev_q;
    if (hit_i.is_flush) begin
      count_d     = '0;
      q_low_d     = '0;
      q_high_d    = '0;
      t_low_d     = '0;
      t_high_d    = '0;
      prev_diag_d = '0;
      have_prev_d = 1'b0;
    end else if (gap_break || !have_prev_q) begin
      // open a fresh clump on this hit
      count_d     = 32'd1;
      q_low_d     = hit_i.query_pos;
      q_high_d    = hit_i.query_pos;
      t_low_d     = hit_i.target_pos;
      t_high_d    = hit_i.target_pos;
      prev_diag_d = hit_i.diag;
      have_prev_d = 1'b1;
    end else begin
      if (count_q != '1) begin
        count_d = count_q + 32'd1;
      end
      if (hit_i.query_pos < q_low_q)   q_low_d  = hit_i.query_pos;
      if (hit_i.query_pos > q_high_q)  q_high_d = hit_i.query_pos;
      if (hit_i.target_pos < t_low_q)  t_low_d  = hit_i.target_pos;
      if (hit_i.target_pos > t_high_q) t_high_d = hit_i.target_pos;
      prev_diag_d = hit_i.diag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      q_low_q     <= '0;
      q_high_q    <= '0;
      t_low_q     <= '0;
      t_high_q    <= '0;
      prev_diag_q <= '0;
      have_prev_q <= 1'b0;
    end else if (step_i) begin
      count_q     <= count_d;
      q_low_q     <= q_low_d;
      q_high_q    <= q_high_d;
      t_low_q     <= t_low_d;
      t_high_q    <= t_high_d;
      prev_diag_q <= prev_diag_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

/* hdl/dhc_out_reg.sv */
// Result register for closed clumps, decoupling the downstream ready.
// Depends on dhc_pkg.
module dhc_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  dhc_pkg::clump_t result_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dhc_pkg::clump_t result_o
);

  logic            valid_d, valid_q;
  dhc_pkg::clump_t result_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* hdl/dhc_checker.sv */
// Port-level checker for the diagonal hit clumper, bound to the top level.
// Depends on diagonal_hit_clumper_defines.svh.
`include "diagonal_hit_clumper_defines.svh"

module dhc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] query_first_o,
  input logic [31:0] query_end_o,
  input logic [31:0] target_first_o,
  input logic [31:0] target_end_o,
  input logic [31:0] clump_hits_o
);

  logic         out_stall;
  logic [159:0] out_payload;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign out_payload = {query_first_o, query_end_o, target_first_o, target_end_o,
                        clump_hits_o};

  // A stalled result transaction holds valid and payload.
  `DHC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_payload), "result not held")

  // Input backpressure comes only from an untaken result.
  `DHC_ASSERT_NOW(a_in_stall, !in_ready_o, out_stall, "input stalled without backpressure")

  // A reported clump always holds at least one hit.
  `DHC_ASSERT_NOW(a_hits_nonzero, out_valid_o, clump_hits_o != 32'd0, "empty clump reported")

  // Configuration writes are never refused.
  `DHC_ASSERT_NOW(a_cfg_ready, cfg_valid_i, cfg_ready_o, "configuration write refused")

endmodule

bind diagonal_hit_clumper dhc_checker u_dhc_checker (.*);
